/* hw/rtl/spkd_pkg.sv */
package spkd_pkg;

	// default datapath sizing
	localparam int SAMPLE_BITS_DEF = 14;
	localparam int FRAC_BITS_DEF   = 16;

	// fixed field widths
	localparam int FIELD_BITS  = 14;
	localparam int ALPHA_BITS  = 16;
	localparam int TIME_BITS   = 32;
	localparam int COUNT_BITS  = 8;
	localparam int PADDR_BITS  = 4;
	localparam int PDATA_BITS  = 32;

	// item opcodes
	localparam logic OP_SAMPLE = 1'b0;
	localparam logic OP_CLEAR  = 1'b1;

	// register indexes (word address paddr[3:2])
	localparam logic [1:0] REG_EMA_ALPHA     = 2'd0;
	localparam logic [1:0] REG_SPIKE_THRESH  = 2'd1;
	localparam logic [1:0] REG_DEBOUNCE      = 2'd2;
	localparam logic [1:0] REG_PRIME_SAMPLES = 2'd3;

	// register reset values
	localparam logic [ALPHA_BITS-1:0] RST_EMA_ALPHA     = 16'd3277;
	localparam logic [FIELD_BITS-1:0] RST_SPIKE_THRESH  = 14'd500;
	localparam logic [TIME_BITS-1:0]  RST_DEBOUNCE      = 32'd1000;
	localparam logic [COUNT_BITS-1:0] RST_PRIME_SAMPLES = 8'd10;

	typedef struct packed {
		logic                  opcode;
		logic [FIELD_BITS-1:0] sample_ma;
		logic [TIME_BITS-1:0]  timestamp_ms;
	} in_item_t;

	typedef struct packed {
		logic [FIELD_BITS-1:0] latest_ma;
		logic [FIELD_BITS-1:0] baseline_ma;
		logic                  spike_pending;
		logic                  spike_fired;
		logic                  armed;
	} out_item_t;

	typedef struct packed {
		logic [ALPHA_BITS-1:0] ema_alpha;
		logic [FIELD_BITS-1:0] spike_threshold_ma;
		logic [TIME_BITS-1:0]  debounce_ms;
		logic [COUNT_BITS-1:0] prime_samples;
	} cfg_t;

endpackage

/* hw/rtl/spkd_regs.sv */
module spkd_regs (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [spkd_pkg::PADDR_BITS-1:0]  paddr,
	input  logic [spkd_pkg::PDATA_BITS-1:0]  pwdata,
	output logic [spkd_pkg::PDATA_BITS-1:0]  prdata,
	output logic                             pready,
	output spkd_pkg::cfg_t                   cfg
);

	spkd_pkg::cfg_t cfg_q;
	logic           wr_en;
	logic [1:0]     reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite;
	assign reg_idx = paddr[3:2];
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.ema_alpha          <= spkd_pkg::RST_EMA_ALPHA;
			cfg_q.spike_threshold_ma <= spkd_pkg::RST_SPIKE_THRESH;
			cfg_q.debounce_ms        <= spkd_pkg::RST_DEBOUNCE;
			cfg_q.prime_samples      <= spkd_pkg::RST_PRIME_SAMPLES;
		end else if (wr_en) begin
			case (reg_idx)
				spkd_pkg::REG_EMA_ALPHA: begin
					cfg_q.ema_alpha <= pwdata[spkd_pkg::ALPHA_BITS-1:0];
				end
				spkd_pkg::REG_SPIKE_THRESH: begin
					cfg_q.spike_threshold_ma <= pwdata[spkd_pkg::FIELD_BITS-1:0];
				end
				spkd_pkg::REG_DEBOUNCE: begin
					cfg_q.debounce_ms <= pwdata[spkd_pkg::TIME_BITS-1:0];
				end
				spkd_pkg::REG_PRIME_SAMPLES: begin
					cfg_q.prime_samples <= pwdata[spkd_pkg::COUNT_BITS-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			spkd_pkg::REG_EMA_ALPHA:     prdata = spkd_pkg::PDATA_BITS'(cfg_q.ema_alpha);
			spkd_pkg::REG_SPIKE_THRESH:  prdata = spkd_pkg::PDATA_BITS'(cfg_q.spike_threshold_ma);
			spkd_pkg::REG_DEBOUNCE:      prdata = spkd_pkg::PDATA_BITS'(cfg_q.debounce_ms);
			spkd_pkg::REG_PRIME_SAMPLES: prdata = spkd_pkg::PDATA_BITS'(cfg_q.prime_samples);
			default:                     prdata = '0;
		endcase
	end

endmodule

/* hw/rtl/spkd_core.sv */
module spkd_core #(
	parameter int SAMPLE_BITS = spkd_pkg::SAMPLE_BITS_DEF,
	parameter int FRAC_BITS   = spkd_pkg::FRAC_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                fire,
	input  spkd_pkg::in_item_t  item,
	input  spkd_pkg::cfg_t      cfg,
	output spkd_pkg::out_item_t result
);

	localparam int ACC_BITS  = SAMPLE_BITS + FRAC_BITS;
	localparam int AB        = spkd_pkg::ALPHA_BITS;
	localparam int PROD_BITS = ACC_BITS + AB;
	localparam int CMP_BITS  = ACC_BITS + spkd_pkg::FIELD_BITS;
	localparam int SAT_BITS  = (SAMPLE_BITS > spkd_pkg::FIELD_BITS) ?
		SAMPLE_BITS : spkd_pkg::FIELD_BITS;
	localparam logic [SAT_BITS-1:0]  SMAX  = SAT_BITS'((64'd1 << SAMPLE_BITS) - 64'd1);
	localparam logic [PROD_BITS-1:0] ROUND = PROD_BITS'((64'd1 << AB) - 64'd1);

	// state
	logic [SAMPLE_BITS-1:0]          latest_q, latest_n;
	logic [ACC_BITS-1:0]             acc_q, acc_n;
	logic [spkd_pkg::COUNT_BITS-1:0] count_q, count_n;
	logic                            flag_q, flag_n;
	logic [spkd_pkg::TIME_BITS-1:0]  last_q, last_n;

	logic [SAT_BITS-1:0]    sample_ext;
	logic [SAMPLE_BITS-1:0] smp;
	logic [ACC_BITS-1:0]    xf;
	logic                   go_up;
	logic [ACC_BITS-1:0]    mag;
	logic [PROD_BITS-1:0]   prod, prod_rnd;
	logic [ACC_BITS-1:0]    step_up, step_dn;
	logic [ACC_BITS:0]      up_sum;
	logic [ACC_BITS-1:0]    acc_up, acc_dn, acc_ema;
	logic [CMP_BITS-1:0]    excess, thr_f;
	logic [spkd_pkg::TIME_BITS-1:0] dt;
	logic                   priming, spike, fired;

	// saturate to the datapath range
	assign sample_ext = SAT_BITS'(item.sample_ma);
	assign smp        = SAMPLE_BITS'((sample_ext > SMAX) ? SMAX : sample_ext);
	assign xf         = {smp, {FRAC_BITS{1'b0}}};

	// EMA step: floor on the way up, ceil of magnitude on the way down
	assign go_up    = xf >= acc_q;
	assign mag      = go_up ? (xf - acc_q) : (acc_q - xf);
	assign prod     = PROD_BITS'(mag) * PROD_BITS'(cfg.ema_alpha);
	assign prod_rnd = prod + ROUND;
	assign step_up  = prod[PROD_BITS-1:AB];
	assign step_dn  = prod_rnd[PROD_BITS-1:AB];
	assign up_sum   = {1'b0, acc_q} + {1'b0, step_up};
	assign acc_up   = up_sum[ACC_BITS] ? {ACC_BITS{1'b1}} : up_sum[ACC_BITS-1:0];
	assign acc_dn   = (step_dn > acc_q) ? '0 : (acc_q - step_dn);
	assign acc_ema  = go_up ? acc_up : acc_dn;

	// spike test against the updated baseline
	assign excess = CMP_BITS'(xf - acc_ema);
	assign thr_f  = CMP_BITS'({cfg.spike_threshold_ma, {FRAC_BITS{1'b0}}});
	assign dt     = item.timestamp_ms - last_q;
	assign spike  = !flag_q && (xf > acc_ema) && (excess > thr_f) &&
		(dt >= cfg.debounce_ms);

	assign priming = count_q < cfg.prime_samples;

	always_comb begin
		latest_n = latest_q;
		acc_n    = acc_q;
		count_n  = count_q;
		flag_n   = flag_q;
		last_n   = last_q;
		fired    = 1'b0;
		if (item.opcode == spkd_pkg::OP_CLEAR) begin
			flag_n = 1'b0;
		end else begin
			latest_n = smp;
			if (priming) begin
				acc_n   = xf;
				count_n = count_q + 1'b1;
			end else begin
				acc_n = acc_ema;
				if (spike) begin
					flag_n = 1'b1;
					last_n = item.timestamp_ms;
					fired  = 1'b1;
				end
			end
		end
	end

	always_comb begin
		result.latest_ma     = spkd_pkg::FIELD_BITS'(latest_n);
		result.baseline_ma   = spkd_pkg::FIELD_BITS'(acc_n[ACC_BITS-1:FRAC_BITS]);
		result.spike_pending = flag_n;
		result.spike_fired   = fired;
		result.armed         = count_n >= cfg.prime_samples;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			latest_q <= '0;
			acc_q    <= '0;
			count_q  <= '0;
			flag_q   <= 1'b0;
			last_q   <= '0;
		end else if (fire) begin
			latest_q <= latest_n;
			acc_q    <= acc_n;
			count_q  <= count_n;
			flag_q   <= flag_n;
			last_q   <= last_n;
		end
	end

endmodule

/* hw/rtl/ema_spike_detector_debounced.sv */
// Current spike detector with an EMA baseline and a latched, debounced event
// flag. Each item on the sample channel is either a current sample in mA with
// a wrapping ms timestamp (opcode OP_SAMPLE) or a command that clears the
// latched flag (opcode OP_CLEAR); every item yields exactly one result item.
// The first prime_samples samples load the baseline directly; after that the
// baseline moves by an EMA step of weight ema_alpha (Q0.16), and a sample is
// a spike when it exceeds the new baseline by more than spike_threshold_ma,
// the flag is clear and at least debounce_ms have elapsed (wrapping 32-bit
// difference) since the last event. Samples above 2^SAMPLE_BITS-1 saturate.
// Throughput is one item per clock while result_stall is low; an accepted
// item is held in stage 1, its result in the result register (stage 2) that
// drives result_item. The limit is the state loop: the EMA multiply, clamp
// and spike compares for one item are combinational between the two. APB
// registers sit at byte addresses 0, 4, 8, 12; the user must write them only
// while the block is idle, which the block itself does not enforce.
module ema_spike_detector_debounced #(
	parameter int SAMPLE_BITS = spkd_pkg::SAMPLE_BITS_DEF,
	parameter int FRAC_BITS   = spkd_pkg::FRAC_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// sample channel
	input  logic                            sample_valid,
	output logic                            sample_stall,
	input  spkd_pkg::in_item_t              sample_item,
	// result channel
	output logic                            result_valid,
	input  logic                            result_stall,
	output spkd_pkg::out_item_t             result_item,
	// configuration
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [spkd_pkg::PADDR_BITS-1:0] paddr,
	input  logic [spkd_pkg::PDATA_BITS-1:0] pwdata,
	output logic [spkd_pkg::PDATA_BITS-1:0] prdata,
	output logic                            pready
);

	spkd_pkg::cfg_t      cfg;
	spkd_pkg::in_item_t  item_s1;
	logic                valid_s1;
	spkd_pkg::out_item_t res_s2;
	logic                valid_s2;
	spkd_pkg::out_item_t core_res;

	logic take;     // item accepted into stage 1
	logic adv_s2;   // result register can load
	logic adv_s1;   // stage 1 item is processed and state updated

	spkd_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	spkd_core #(
		.SAMPLE_BITS (SAMPLE_BITS),
		.FRAC_BITS   (FRAC_BITS)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (adv_s1),
		.item   (item_s1),
		.cfg    (cfg),
		.result (core_res)
	);

	// Result register loads whenever it is empty or being drained, so a
	// waiting result does not keep stage 1 from taking the next item
	// unless both are full.
	assign adv_s2       = !valid_s2 || !result_stall;
	assign adv_s1       = valid_s1 && adv_s2;
	assign sample_stall = valid_s1 && !adv_s2;
	assign take         = sample_valid && !sample_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (take) begin
				valid_s1 <= 1'b1;
			end else if (adv_s1) begin
				valid_s1 <= 1'b0;
			end
			if (adv_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	// payload registers, no reset
	always_ff @(posedge clk) begin
		if (take) begin
			item_s1 <= sample_item;
		end
		if (adv_s1) begin
			res_s2 <= core_res;
		end
	end

	assign result_valid = valid_s2;
	assign result_item  = res_s2;

	// stall toward the source only when stage 1 and the result register both hold an item
	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		sample_stall |-> valid_s1 && valid_s2)
		else $error("sample_stall without full pipeline");

	// a held stage 1 item must not change underneath the core
	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv_s1 |=> valid_s1 && $stable(item_s1))
		else $error("stage 1 item lost or changed while held");

	// a newly fired spike only happens when armed and leaves the flag set
	a_fire_armed: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_item.spike_fired |->
			result_item.armed && result_item.spike_pending)
		else $error("spike fired while unarmed or flag clear");

	// a result taken while stage 1 is empty leaves the output empty
	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_stall && !valid_s1 |=> !result_valid)
		else $error("result repeated after being taken");

endmodule

/* tb/tb.sv */
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import spkd_pkg::*;

	// Datapath sizing at the block's default parameters
	localparam int FRAC     = FRAC_BITS_DEF;
	localparam int ACC_BITS = SAMPLE_BITS_DEF + FRAC_BITS_DEF;
	localparam logic [63:0] ACC_MAX = (64'd1 << ACC_BITS) - 64'd1;
	localparam int MA_MAX   = (1 << FIELD_BITS) - 1;

	// Quiet cycles (nothing accepted on either channel) before giving up.
	// The longest quiet stretch is the forced receiver hold-off (HOLD_OFF_CYCLES).
	localparam int QUIET_LIMIT     = 2000;
	localparam int HOLD_OFF_CYCLES = 120;

	logic clk = 1'b0;
	logic arst_n;

	logic        sample_valid;
	logic        sample_stall;
	in_item_t    sample_item;
	logic        result_valid;
	logic        result_stall;
	out_item_t   result_item;

	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [PADDR_BITS-1:0] paddr;
	logic [PDATA_BITS-1:0] pwdata;
	logic [PDATA_BITS-1:0] prdata;
	logic                  pready;

	ema_spike_detector_debounced dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.sample_item  (sample_item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result_item  (result_item),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	always #6 clk = ~clk;

	// ------------------------------------------------------------------
	// Shadow of the detector: register copy plus its own baseline state
	// ------------------------------------------------------------------
	cfg_t cfg_shadow = '{
		ema_alpha:          RST_EMA_ALPHA,
		spike_threshold_ma: RST_SPIKE_THRESH,
		debounce_ms:        RST_DEBOUNCE,
		prime_samples:      RST_PRIME_SAMPLES
	};

	logic [FIELD_BITS-1:0] latest_seen    = '0;
	logic [ACC_BITS-1:0]   base_acc       = '0;
	logic [COUNT_BITS-1:0] primed_count   = '0;
	logic                  flag_latched   = 1'b0;
	logic [TIME_BITS-1:0]  last_spike_ms  = '0;

	out_item_t expected_q[$];
	int        fail_count = 0;

	// Idle controls shared by sender and receiver
	bit idle_allowed = 1'b1;
	bit gaps_on      = 1'b1;
	bit bursts_on    = 1'b1;
	int hold_off_cycles = 0;

	// Traffic shaping state for the random part
	logic [TIME_BITS-1:0] ts_clock   = 32'd20000;
	int                   load_level = 3000;

	// Advance the detector shadow by one item and return the result it owes.
	function automatic out_item_t detect_step(in_item_t it);
		out_item_t            r;
		logic [63:0]          xf;
		logic [63:0]          acc;
		logic [63:0]          move;
		logic [TIME_BITS-1:0] elapsed;
		logic                 fired;
		fired = 1'b0;
		if (it.opcode == OP_CLEAR) begin
			flag_latched = 1'b0;
		end else begin
			// sample field is exactly SAMPLE_BITS wide, so saturation never bites here
			latest_seen = it.sample_ma;
			xf = 64'(it.sample_ma) << FRAC;
			if (primed_count < cfg_shadow.prime_samples) begin
				// priming: baseline loads straight from the sample
				base_acc = xf[ACC_BITS-1:0];
				primed_count = primed_count + 1'b1;
			end else begin
				acc = 64'(base_acc);
				if (xf >= acc) begin
					// upward step rounds toward zero (floor of a positive delta)
					move = ((xf - acc) * 64'(cfg_shadow.ema_alpha)) >> ALPHA_BITS;
					acc = acc + move;
					if (acc > ACC_MAX)
						acc = ACC_MAX;
				end else begin
					// downward step: floor of a negative delta = ceil of magnitude
					move = ((acc - xf) * 64'(cfg_shadow.ema_alpha)
						+ ((64'd1 << ALPHA_BITS) - 64'd1)) >> ALPHA_BITS;
					acc = (move > acc) ? 64'd0 : acc - move;
				end
				base_acc = acc[ACC_BITS-1:0];
				// wrapping 32-bit age of the last event
				elapsed = it.timestamp_ms - last_spike_ms;
				if (!flag_latched && xf > acc
						&& (xf - acc) > (64'(cfg_shadow.spike_threshold_ma) << FRAC)
						&& elapsed >= cfg_shadow.debounce_ms) begin
					flag_latched = 1'b1;
					last_spike_ms = it.timestamp_ms;
					fired = 1'b1;
				end
			end
		end
		r.latest_ma     = latest_seen;
		r.baseline_ma   = base_acc[ACC_BITS-1 -: FIELD_BITS];
		r.spike_pending = flag_latched;
		r.spike_fired   = fired;
		r.armed         = (primed_count >= cfg_shadow.prime_samples);
		return r;
	endfunction

	task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			fail_count++;
		end
	endtask

	// ------------------------------------------------------------------
	// Monitor: results are checked against the oldest expectation first,
	// then an accepted input item queues its own expectation. Doing both in
	// one block keeps the order fixed when the two happen on the same edge.
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n) begin
			if (result_valid && !result_stall) begin
				if (expected_q.size() == 0) begin
					$error("result item with no expectation pending");
					fail_count++;
				end else begin
					out_item_t want;
					want = expected_q.pop_front();
					compare_field("latest_ma", 32'(want.latest_ma),
						32'(result_item.latest_ma));
					compare_field("baseline_ma", 32'(want.baseline_ma),
						32'(result_item.baseline_ma));
					compare_field("spike_pending", 32'(want.spike_pending),
						32'(result_item.spike_pending));
					compare_field("spike_fired", 32'(want.spike_fired),
						32'(result_item.spike_fired));
					compare_field("armed", 32'(want.armed), 32'(result_item.armed));
				end
			end
			if (sample_valid && !sample_stall)
				expected_q.push_back(detect_step(sample_item));
		end
	end

	// Watchdog: declares the run hung and fails when handshakes stop on both channels.
	initial begin
		int quiet_cycles;
		quiet_cycles = 0;
		while (quiet_cycles < QUIET_LIMIT) begin
			@(posedge clk);
			if ((sample_valid && !sample_stall) || (result_valid && !result_stall))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("tb: FAIL");
		$finish;
	end

	// Receiver: random stall bursts, or one long forced hold-off on request.
	initial begin
		result_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_off_cycles > 0) begin
				result_stall <= 1'b1;
				repeat (hold_off_cycles) @(posedge clk);
				hold_off_cycles = 0;
				result_stall <= 1'b0;
			end else if (bursts_on && $urandom_range(0, 5) == 0) begin
				result_stall <= 1'b1;
				repeat ($urandom_range(1, 4)) @(posedge clk);
				result_stall <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------
	// Sender side
	// ------------------------------------------------------------------

	// Offer one item and return at the edge that accepts it. Valid stays up
	// afterwards so back-to-back items need no drop in between.
	task automatic send_item(in_item_t it);
		if (gaps_on && $urandom_range(0, 5) == 0) begin
			sample_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		sample_valid <= 1'b1;
		sample_item  <= it;
		do @(posedge clk); while (sample_stall);
	endtask

	task automatic send_sample(int ma, logic [31:0] ts);
		send_item('{opcode: OP_SAMPLE, sample_ma: FIELD_BITS'(ma), timestamp_ms: ts});
	endtask

	// Clear carries junk in the unused fields on purpose.
	task automatic send_clear();
		send_item('{opcode: OP_CLEAR, sample_ma: FIELD_BITS'($urandom()),
			timestamp_ms: $urandom()});
	endtask

	// Stop offering and wait for every outstanding result. Every item yields
	// a result, so an empty queue means the block is idle. The first edge
	// lets the monitor queue an item accepted at the edge we were called on.
	task automatic drain_results();
		sample_valid <= 1'b0;
		@(posedge clk);
		while (expected_q.size() != 0) @(posedge clk);
	endtask

	// APB write: setup cycle, then access cycle until pready, then an idle step
	// with psel low so back-to-back writes never drive the bus twice on one edge.
	task automatic cfg_write(logic [1:0] idx, logic [31:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		case (idx)
			REG_EMA_ALPHA:     cfg_shadow.ema_alpha          = value[ALPHA_BITS-1:0];
			REG_SPIKE_THRESH:  cfg_shadow.spike_threshold_ma = value[FIELD_BITS-1:0];
			REG_DEBOUNCE:      cfg_shadow.debounce_ms        = value[TIME_BITS-1:0];
			REG_PRIME_SAMPLES: cfg_shadow.prime_samples      = value[COUNT_BITS-1:0];
			default: ;
		endcase
	endtask

	function automatic logic [FIELD_BITS-1:0] clamp_ma(int v);
		if (v < 0)
			return '0;
		if (v > MA_MAX)
			return FIELD_BITS'(MA_MAX);
		return v[FIELD_BITS-1:0];
	endfunction

	// Time between samples: mostly short hops, often near the debounce
	// window edge, rarely an arbitrary jump that exercises wraparound.
	function automatic logic [31:0] next_gap_ms();
		int unsigned roll;
		roll = $urandom_range(0, 9);
		if (roll < 5)
			return $urandom_range(0, 40);
		if (roll < 9)
			return cfg_shadow.debounce_ms + $urandom_range(0, 40) - 32'd20;
		return $urandom();
	endfunction

	// Load-like traffic: samples hover around a level with spikes above the
	// threshold, occasional clears, level shifts, and some pure noise.
	task automatic run_traffic(int unsigned n_items);
		int unsigned roll;
		int          thr;
		for (int unsigned k = 0; k < n_items; k++) begin
			if (k % 50 == 0) begin
				gaps_on   = idle_allowed && ($urandom_range(0, 3) != 0);
				bursts_on = idle_allowed && ($urandom_range(0, 3) != 0);
			end
			thr  = int'(cfg_shadow.spike_threshold_ma);
			roll = $urandom_range(0, 99);
			if (roll < 8) begin
				send_clear();
			end else if (roll < 12) begin
				send_sample(int'($urandom_range(0, MA_MAX)), $urandom());
			end else begin
				if (roll < 15)
					load_level = int'($urandom_range(0, MA_MAX));
				ts_clock = ts_clock + next_gap_ms();
				if (roll < 40)
					send_sample(
						int'(clamp_ma(load_level + thr + int'($urandom_range(1, 300)))),
						ts_clock);
				else
					send_sample(
						int'(clamp_ma(load_level + int'($urandom_range(0, 128)) - 64)),
						ts_clock);
			end
		end
	endtask

	task automatic run_phase(input logic [31:0] alpha, thr, deb, prime,
			input int unsigned n_items);
		drain_results();
		cfg_write(REG_EMA_ALPHA, alpha);
		cfg_write(REG_SPIKE_THRESH, thr);
		cfg_write(REG_DEBOUNCE, deb);
		cfg_write(REG_PRIME_SAMPLES, prime);
		run_traffic(n_items);
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Reset registers: clear before any sample, ten priming samples with the
	// field extremes, then spike, held flag, debounce boundary and wraparound.
	task automatic test_priming_and_debounce();
		send_clear();
		send_sample(MA_MAX, 32'd0);
		send_sample(0, 32'hFFFF_FFFF);
		for (int i = 0; i < 7; i++)
			send_sample(int'($urandom_range(0, MA_MAX)), 32'(10 * i));
		send_sample(1000, 32'd100);      // last priming sample, arms detection
		send_sample(MA_MAX, 32'd5000);   // first spike
		send_sample(MA_MAX, 32'd7000);   // flag already latched, no new event
		send_clear();
		send_sample(MA_MAX, 32'd5500);   // inside debounce window
		send_sample(MA_MAX, 32'd6000);   // exactly debounce_ms later: fires
		send_clear();
		send_sample(MA_MAX, 32'd5999);   // backwards time wraps to a huge age
		send_clear();
	endtask

	// Raising prime_samples resumes priming, then a frozen baseline (alpha 0)
	// hits the strict threshold compare exactly; then lowering prime_samples to
	// zero and a near full-weight EMA in both directions.
	task automatic test_threshold_edges();
		drain_results();
		cfg_write(REG_EMA_ALPHA, 32'd0);
		cfg_write(REG_SPIKE_THRESH, 32'd100);
		cfg_write(REG_DEBOUNCE, 32'd0);
		cfg_write(REG_PRIME_SAMPLES, 32'd12);
		send_sample(2000, 32'd9000);     // priming resumes
		send_sample(2000, 32'd9001);     // baseline exactly 2000.0
		send_sample(2100, 32'd9002);     // excess equals threshold: no spike
		send_sample(2101, 32'd9003);     // one over: spike
		send_clear();
		send_sample(1000, 32'd9004);     // below baseline
		drain_results();
		cfg_write(REG_EMA_ALPHA, 32'd65535);
		cfg_write(REG_SPIKE_THRESH, 32'd0);
		cfg_write(REG_PRIME_SAMPLES, 32'd0);
		send_sample(0, 32'd9100);
		send_sample(MA_MAX, 32'd9101);
	endtask

	// Register sweep, extremes included, with load-like traffic in each phase.
	task automatic test_register_sweep();
		run_phase(32'd3277, 32'd500, 32'd1000, 32'd30, 195);
		run_phase(32'd65535, 32'd0, 32'd0, 32'd0, 195);
		run_phase(32'd0, 32'd16383, 32'hFFFF_FFFF, 32'd5, 195);
		// upper bits beyond each register's width are junk
		run_phase($urandom(), $urandom(), $urandom_range(0, 3000),
			($urandom() & 32'hFFFF_FF00) | $urandom_range(0, 60), 195);
		run_phase(32'd1, 32'd200, 32'd50, 32'd40, 195);
		run_phase(32'd50000, 32'd1000, 32'd0, 32'd0, 195);
		run_phase($urandom(), $urandom_range(0, 800), $urandom_range(0, 500),
			$urandom_range(0, 80), 195);
		run_phase(32'd20000, 32'd300, 32'd100, 32'd255, 280);
	endtask

	// Receiver holds off long enough for the block to fill and stall its
	// input while the sender keeps offering.
	task automatic test_receiver_hold_off();
		drain_results();
		cfg_write(REG_EMA_ALPHA, 32'd8000);
		cfg_write(REG_SPIKE_THRESH, 32'd200);
		cfg_write(REG_DEBOUNCE, 32'd30);
		cfg_write(REG_PRIME_SAMPLES, 32'd8);
		hold_off_cycles = HOLD_OFF_CYCLES;
		run_traffic(60);
	endtask

	// Sender goes silent until the pipeline is empty, then resumes.
	task automatic test_sender_pause();
		run_traffic(20);
		drain_results();
		run_traffic(20);
	endtask

	// Closing stretch with no idling on either side.
	task automatic test_steady_stream();
		idle_allowed = 1'b0;
		gaps_on      = 1'b0;
		bursts_on    = 1'b0;
		run_phase(32'd6000, 32'd150, 32'd20, 32'd0, 150);
	endtask

	initial begin
		arst_n       <= 1'b0;
		sample_valid <= 1'b0;
		sample_item  <= '0;
		psel         <= 1'b0;
		penable      <= 1'b0;
		pwrite       <= 1'b0;
		paddr        <= '0;
		pwdata       <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_priming_and_debounce();
		test_threshold_edges();
		test_register_sweep();
		test_receiver_hold_off();
		test_sender_pause();
		test_steady_stream();

		drain_results();
		// wait on after the drain so that stray results are caught
		repeat (10) @(posedge clk);
		if (expected_q.size() != 0) begin
			$error("%0d expected results never arrived", expected_q.size());
			fail_count++;
		end
		if (fail_count == 0)
			$display("tb: PASS");
		else
			$display("tb: FAIL");
		$finish;
	end

endmodule

/* filelist.f */
hw/rtl/spkd_pkg.sv
hw/rtl/spkd_regs.sv
hw/rtl/spkd_core.sv
hw/rtl/ema_spike_detector_debounced.sv
tb/tb.sv
